>>> design/ipv4f_pkg.sv
// Shared types and constants for the IPv4 subnet deny filter.
// Holds the operation and status codes, the chain token and the prefix mask builder.
// No dependencies.
`timescale 1ns / 1ps

package ipv4f_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PLEN_W   = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OCOUNT_W = 5;
  localparam int unsigned IN_DW    = 40;
  localparam int unsigned OUT_DW   = 8;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_PREFIX = 2'd2;

  localparam logic [PLEN_W-1:0] MAX_PREFIX = 6'd32;

  // Token moved one cell per cycle along the rule chain.
  typedef struct packed {
    logic              valid;
    logic              check;
    logic              wr;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
  } token_t;

  // Top plen bits set; a plen above 32 sets every bit.
  function automatic logic [ADDR_W-1:0] prefix_to_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = ({1'b0, 6'(i)} + {1'b0, plen}) >= 7'd32;
    end
    return m;
  endfunction

endpackage

>>> design/ipv4_subnet_deny_filter.sv
// Top level of the IPv4 subnet deny filter: stream ports, rule count, result register.
// Depends on ipv4f_pkg and ipv4f_cell.
`timescale 1ns / 1ps
//
//  channel | dir | tdata (low bit up)                             | tuser
//  --------+-----+------------------------------------------------+-----------
//  s_axis  | in  | address[31:0], prefix_len[37:32], zero[39:38]  | operation
//  m_axis  | out | permitted[0], status[2:1], rule_count[7:3]     | -
//
//  One transfer at a time walks a chain of MAX_RULES rule cells, one cell per
//  cycle; its result is registered once the token leaves the last cell, and the
//  next transfer is taken after the controller returns to idle, so the chain
//  depth sets the time each item takes. Reset clears the rule count, the chain
//  tokens and the output valid; rule storage is not cleared. A stalled output
//  holds the finished result; the next input is taken while that result waits,
//  but a result that finishes while the output is still full is parked in the
//  controller and holds off the input until the output drains.

module ipv4_subnet_deny_filter #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // address[31:0], prefix_len[37:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // permitted[0], status[2:1], rule_count[7:3]
);
  import ipv4f_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
  localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_DW-1:0]   out_data_q, out_data_d;
  logic [STAT_W-1:0]   res_status_q, res_status_d;
  logic [CNT_W-1:0]    res_count_q, res_count_d;
  logic                res_check_q, res_check_d;
  logic                hold_perm_q, hold_perm_d;

  logic [OP_W-1:0]     in_op;
  logic [ADDR_W-1:0]   in_addr;
  logic [PLEN_W-1:0]   in_plen;
  logic                in_acc;
  logic                out_free;
  logic                perm_end;
  logic                add_ok;

  token_t              tok   [0:MAX_RULES];
  logic [CNT_W-1:0]    lim   [0:MAX_RULES];
  logic [IDX_W-1:0]    slot  [0:MAX_RULES];

  assign in_op   = s_axis_tuser;
  assign in_addr = s_axis_tdata[ADDR_W-1:0];
  assign in_plen = s_axis_tdata[ADDR_W+PLEN_W-1:ADDR_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // An add lands when the prefix is legal and the table has room.
  assign add_ok = (in_op == OP_ADD) && (in_plen <= MAX_PREFIX) &&
                  (count_q < CNT_W'(MAX_RULES));

  // Build the token entering the first cell.
  always_comb begin
    tok[0].valid = in_acc;
    tok[0].check = in_acc && (in_op == OP_CHECK);
    tok[0].wr    = in_acc && add_ok;
    tok[0].hit   = 1'b0;
    tok[0].addr  = in_addr;
    tok[0].mask  = prefix_to_mask(in_plen);
    lim[0]       = count_q;
    slot[0]      = IDX_W'(count_q);
  end

  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    ipv4f_cell #(
      .INDEX (g),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .token_i (tok[g]),
      .lim_i   (lim[g]),
      .slot_i  (slot[g]),
      .token_o (tok[g+1]),
      .lim_o   (lim[g+1]),
      .slot_o  (slot[g+1])
    );
  end

  assign perm_end = res_check_q && !tok[MAX_RULES].hit;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_check_d  = res_check_q;
    hold_perm_d  = hold_perm_q;

    // Retire the current output when the consumer takes it.
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_check_d  = (in_op == OP_CHECK);
          res_status_d = ST_OK;
          case (in_op)
            OP_CLEAR: count_d = '0;
            OP_ADD: begin
              if (in_plen > MAX_PREFIX) begin
                res_status_d = ST_BAD_PREFIX;
              end else if (count_q >= CNT_W'(MAX_RULES)) begin
                res_status_d = ST_FULL;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            default: ;
          endcase
          res_count_d = count_d;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        // Wait for the token to leave the last cell.
        if (tok[MAX_RULES].valid) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = {OCOUNT_W'(res_count_q), res_status_q, perm_end};
            state_d     = S_IDLE;
          end else begin
            hold_perm_d = perm_end;
            state_d     = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {OCOUNT_W'(res_count_q), res_status_q, hold_perm_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_check_q  <= res_check_d;
    hold_perm_q  <= hold_perm_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> design/ipv4f_cell.sv
// One rule cell of the deny chain: stores one mask/value pair and matches the passing token.
// Depends on ipv4f_pkg.
`timescale 1ns / 1ps

module ipv4f_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX_W = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ipv4f_pkg::token_t     token_i,
  input  logic [CNT_W-1:0]      lim_i,
  input  logic [IDX_W-1:0]      slot_i,
  output ipv4f_pkg::token_t     token_o,
  output logic [CNT_W-1:0]      lim_o,
  output logic [IDX_W-1:0]      slot_o
);
  import ipv4f_pkg::*;

  token_t             token_q, token_d;
  logic [CNT_W-1:0]   lim_q;
  logic [IDX_W-1:0]   slot_q;
  logic [ADDR_W-1:0]  mask_q;
  logic [ADDR_W-1:0]  value_q;
  logic               match;
  logic               wr_en;

  always_comb begin
    // Only entries below the rule count take part in a check.
    match = token_i.check && (CNT_W'(INDEX) < lim_i) &&
            ((token_i.addr & mask_q) == value_q);
    wr_en = token_i.valid && token_i.wr && (slot_i == IDX_W'(INDEX));
    token_d     = token_i;
    token_d.hit = token_i.hit | match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
    end else begin
      token_q <= token_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q  <= lim_i;
    slot_q <= slot_i;
    if (wr_en) begin
      mask_q  <= token_i.mask;
      value_q <= token_i.addr & token_i.mask;
    end
  end

  assign token_o = token_q;
  assign lim_o   = lim_q;
  assign slot_o  = slot_q;

endmodule

>>> bench/tb.sv
// Self-checking bench for ipv4_subnet_deny_filter: directed and random rule tables.
// Checks each output transfer against an in-bench model of the deny table.
// Depends on ipv4f_pkg and the design files.
`timescale 1ns / 1ps

module tb;
  import ipv4f_pkg::*;

  localparam int unsigned RULE_CAP    = 16;
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] plen;
  } acl_req_t;

  typedef struct packed {
    logic              permitted;
    logic [STAT_W-1:0] status;
    logic [4:0]        count;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;   // address[31:0], prefix_len[37:32], zero pad
  logic [1:0]        s_axis_tuser = '0;   // operation[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // permitted[0], status[2:1], rule_count[7:3]

  ipv4_subnet_deny_filter #(.MAX_RULES(RULE_CAP)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Bench-side copy of the deny table
  logic [ADDR_W-1:0] acl_mask  [RULE_CAP];
  logic [ADDR_W-1:0] acl_value [RULE_CAP];
  int unsigned       acl_count = 0;

  acl_req_t    pending_q [$];
  verdict_t    verdict_q [$];
  int unsigned n_total    = 0;
  int unsigned n_accepted = 0;
  int unsigned n_err      = 0;
  int unsigned cycle_cnt  = 0;

  // Generator-side view of the rules, used to aim check addresses at subnets
  logic [ADDR_W-1:0] gen_addr [$];
  logic [PLEN_W-1:0] gen_plen [$];
  int unsigned       n_items = 0;

  // Driver and receiver pacing
  bit          in_took    = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned pace_cnt   = 0;
  bit          calm;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    if (plen == 0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - plen);
  endfunction

  // Apply one operation to the bench table and return the verdict it should produce
  task automatic apply_acl_op(input acl_req_t req, output verdict_t v);
    logic [ADDR_W-1:0] m;
    bit hit;
    v = '0;
    v.status = ST_OK;
    case (req.op)
      OP_CLEAR: acl_count = 0;
      OP_ADD: begin
        if (req.plen > MAX_PREFIX) begin
          v.status = ST_BAD_PREFIX;
        end else if (acl_count >= RULE_CAP) begin
          v.status = ST_FULL;
        end else begin
          m = prefix_mask(req.plen);
          acl_mask[acl_count]  = m;
          acl_value[acl_count] = req.addr & m;
          acl_count++;
        end
      end
      OP_CHECK: begin
        hit = 1'b0;
        for (int i = 0; i < acl_count; i++) begin
          if ((req.addr & acl_mask[i]) == acl_value[i]) hit = 1'b1;
        end
        v.permitted = !hit;
      end
      default: ;  // unused code: ignored
    endcase
    v.count = acl_count[4:0];
  endtask

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [PLEN_W-1:0] plen);
    acl_req_t r;
    r.op = op;
    r.addr = addr;
    r.plen = plen;
    pending_q.push_back(r);
    n_total++;
    if (op != OP_UNUSED) n_items++;
    // Track successful adds so checks can land inside or just outside a subnet
    if (op == OP_CLEAR) begin
      gen_addr.delete();
      gen_plen.delete();
    end else if (op == OP_ADD && plen <= MAX_PREFIX && gen_addr.size() < RULE_CAP) begin
      gen_addr.push_back(addr);
      gen_plen.push_back(plen);
    end
  endtask

  function automatic logic [PLEN_W-1:0] pick_prefix();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 10) return PLEN_W'($urandom_range(33, 63));
    if (r < 20) return MAX_PREFIX;
    return PLEN_W'($urandom_range(1, 31));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_check_addr();
    int unsigned k;
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] host;
    if (gen_addr.size() == 0 || $urandom_range(0, 99) < 15) return $urandom;
    k = $urandom_range(0, gen_addr.size() - 1);
    m = prefix_mask(gen_plen[k]);
    host = $urandom & ~m;
    case ($urandom_range(0, 2))
      0: return (gen_addr[k] & m) | host;
      // flip the lowest prefix bit: just outside this subnet
      1: if (gen_plen[k] == 0) return host;
         else return ((gen_addr[k] & m) ^ (32'h1 << (ADDR_W - gen_plen[k]))) | host;
      default: return gen_addr[k];
    endcase
  endfunction

  task automatic build_stimulus();
    int unsigned nadd;
    int unsigned nchk;
    // Directed: empty table, host rule, bad prefixes, unused code, fill to full
    queue_req(OP_CHECK, 32'hFFFF_FFFF, '0);
    queue_req(OP_ADD,   32'hFFFF_FFFF, MAX_PREFIX);
    queue_req(OP_CHECK, 32'hFFFF_FFFF, '0);
    queue_req(OP_CHECK, 32'hFFFF_FFFE, 6'd63);
    queue_req(OP_ADD,   32'h0A00_0000, 6'd33);
    queue_req(OP_ADD,   32'h0000_0000, 6'd63);
    queue_req(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    queue_req(OP_ADD,   32'h0AFF_FFFF, 6'd8);
    queue_req(OP_CHECK, 32'h0AFF_FFFF, '0);
    queue_req(OP_CHECK, 32'h0B00_0000, '0);
    queue_req(OP_ADD,   $urandom, '0);
    for (int i = 0; i < RULE_CAP - 3; i++) begin
      queue_req(OP_ADD, $urandom, PLEN_W'($urandom_range(1, 31)));
    end
    queue_req(OP_ADD,   $urandom, 6'd24);   // table full
    queue_req(OP_ADD,   $urandom, 6'd40);   // full and bad prefix: bad prefix wins
    queue_req(OP_CHECK, $urandom, '0);
    queue_req(OP_CLEAR, $urandom, PLEN_W'($urandom));
    queue_req(OP_CHECK, 32'h0000_0000, '0);

    // Random: build a table, then probe it; sometimes keep the table to reach full
    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) queue_req(OP_CLEAR, $urandom, PLEN_W'($urandom));
      nadd = $urandom_range(0, 18);
      for (int i = 0; i < nadd; i++) begin
        queue_req(OP_ADD, $urandom, pick_prefix());
      end
      nchk = $urandom_range(4, 24);
      for (int i = 0; i < nchk; i++) begin
        queue_req(OP_CHECK, pick_check_addr(), PLEN_W'($urandom));
        if ($urandom_range(0, 24) == 0) queue_req(OP_UNUSED, $urandom, PLEN_W'($urandom));
      end
    end
  endtask

  // Track accepted inputs and check output transfers against the oldest verdict
  always @(posedge clk_i) begin
    acl_req_t req;
    verdict_t exp_v;
    verdict_t got;
    in_took = s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got.permitted = m_axis_tdata[0];
      got.status    = m_axis_tdata[2:1];
      got.count     = m_axis_tdata[7:3];
      if (verdict_q.size() == 0) begin
        $error("unexpected output transfer: data %h", m_axis_tdata);
        n_err++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (got.permitted !== exp_v.permitted) begin
          $error("permitted: expected %0d, got %0d", exp_v.permitted, got.permitted);
          n_err++;
        end
        if (got.status !== exp_v.status) begin
          $error("status: expected %0d, got %0d", exp_v.status, got.status);
          n_err++;
        end
        if (got.count !== exp_v.count) begin
          $error("rule_count: expected %0d, got %0d", exp_v.count, got.count);
          n_err++;
        end
      end
    end
    if (in_took) begin
      req.op   = s_axis_tuser;
      req.addr = s_axis_tdata[31:0];
      req.plen = s_axis_tdata[37:32];
      apply_acl_op(req, exp_v);
      verdict_q.push_back(exp_v);
      n_accepted++;
    end
  end

  // Drive inputs and the output ready on the falling edge
  always @(negedge clk_i) begin
    acl_req_t req;
    calm = pending_q.size() < 150;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_took) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req = pending_q.pop_front();
          s_axis_tdata  <= {2'b00, req.plen, req.addr};
          s_axis_tuser  <= req.op;
          s_axis_tvalid <= 1'b1;
          // reroll the pacing now and then, zero included, for stretches with no idling
          pace_cnt++;
          if (pace_cnt % 50 == 0) begin
            gap_pct   = $urandom_range(0, 2) * 15;
            stall_pct = $urandom_range(0, 2) * 15;
          end
          if (!calm && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (n_accepted < n_total) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    // drain: any stray result shows up within a chain traversal
    repeat (2 * RULE_CAP + 8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
